[design/double_ended_queue_ring_defines.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_ring_defines
// Assertion macros used by the deque top-level design file.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_RING_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_RING_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also runs during reset.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants for the double-ended queue cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } result_t;

  // broadcast to every cell; at most one operation bit is set
  typedef struct packed {
    logic                     ins_front;
    logic                     ins_back;
    logic                     del_front;
    logic                     del_back;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic front_valid;
    logic last_valid;
  } row_stat_t;

endpackage

`default_nettype wire

[design/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One queue slot: shifts with its neighbors on front operations, loads or
// drops at the tail on back operations, and feeds the back-value chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  cell_ctl_t                ctl,
  input  wire                      left_valid,
  input  wire signed [DATA_W-1:0]  left_data,
  input  wire                      right_valid,
  input  wire signed [DATA_W-1:0]  right_data,
  input  wire signed [DATA_W-1:0]  tail_in,
  output logic                     valid,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tail_out
);

  logic                     valid_next;
  logic signed [DATA_W-1:0] data_next;
  logic                     is_last;

  assign is_last  = valid && !right_valid;
  assign tail_out = tail_in | (is_last ? data : '0);

  always_comb begin
    valid_next = valid;
    data_next  = data;
    priority if (ctl.ins_front) begin
      valid_next = left_valid;
      data_next  = left_data;
    end else if (ctl.ins_back) begin
      if (!valid && left_valid) begin
        valid_next = 1'b1;
        data_next  = ctl.value;
      end
    end else if (ctl.del_front) begin
      valid_next = right_valid;
      data_next  = right_data;
    end else if (ctl.del_back) begin
      if (is_last) valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

[design/deq_row.sv]
// ----------------------------------------------------------------------------
// deq_row
// Row of queue cells; cell 0 is the front. Gives the front entry, the back
// entry through the tail chain, and occupancy flags at both ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_row
  import deq_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  cell_ctl_t                ctl,
  output logic signed [DATA_W-1:0] front_data,
  output logic signed [DATA_W-1:0] back_data,
  output row_stat_t                stat
);

  logic                     valid_a [CAPACITY];
  logic signed [DATA_W-1:0] data_a  [CAPACITY];
  logic signed [DATA_W-1:0] tail_a  [CAPACITY+1];

  assign tail_a[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lv;
    logic signed [DATA_W-1:0] ld;
    logic                     rv;
    logic signed [DATA_W-1:0] rd;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = ctl.value;
    end else begin : g_mid_l
      assign lv = valid_a[i-1];
      assign ld = data_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = valid_a[i+1];
      assign rd = data_a[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .tail_in     (tail_a[i+1]),
      .valid       (valid_a[i]),
      .data        (data_a[i]),
      .tail_out    (tail_a[i])
    );
  end

  assign front_data       = valid_a[0] ? data_a[0] : '0;
  assign back_data        = tail_a[0];
  assign stat.front_valid = valid_a[0];
  assign stat.last_valid  = valid_a[CAPACITY-1];

endmodule

`default_nettype wire

[design/double_ended_queue_ring.sv]
// An accepted item first sets the busy flag; its result is then registered.
// No new item is taken while busy; the cell row updates in the accept
// cycle and the back value is gathered along the row's tail chain in the next.
// A result left waiting blocks the next item until it is taken.
// Reset: synchronous, active high; empties the queue (count zero, all cells
// invalid); cell data is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_ring
// Bounded double-ended queue of signed 32-bit values built as a cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_ring_defines.svh"

module double_ended_queue_ring
  import deq_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      request_valid,
  output logic     request_ready,
  input  request_t request,
  output logic     result_valid,
  input  wire      result_ready,
  output result_t  result
);

  logic                     accept;
  logic                     busy;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  status_t                  status_q;
  status_t                  status_next;
  logic                     is_full;
  logic                     is_empty;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] front_data;
  logic signed [DATA_W-1:0] back_data;
  row_stat_t                row_stat;

  assign request_ready = !busy && (!result_valid || result_ready);
  assign accept        = request_valid && request_ready;
  assign is_full       = (count == CNT_W'(CAPACITY));
  assign is_empty      = (count == '0);

  always_comb begin
    ctl         = '0;
    ctl.value   = request.value;
    status_next = ST_DONE;
    count_next  = count;
    unique case (request.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins_front = accept && (request.operation == OP_PUSH_FRONT);
          ctl.ins_back  = accept && (request.operation == OP_PUSH_BACK);
          count_next    = count + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.del_front = accept && (request.operation == OP_POP_FRONT);
          ctl.del_back  = accept && (request.operation == OP_POP_BACK);
          count_next    = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  deq_row u_row (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .front_data (front_data),
    .back_data  (back_data),
    .stat       (row_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      busy <= accept;
      if (accept) count <= count_next;
      if (busy) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) status_q <= status_next;
    if (busy) begin
      result.status      <= status_q;
      result.count       <= COUNT_W'(count);
      result.front_value <= front_data;
      result.back_value  <= back_data;
    end
  end

  `DEQ_ASSERT(a_busy_gives_result, busy |=> result_valid, "result missing after update")
  `DEQ_ASSERT(a_empty_matches_row, (count == '0) == !row_stat.front_valid, "count and row disagree on empty")
  `DEQ_ASSERT(a_full_matches_row, (count == CNT_W'(CAPACITY)) == row_stat.last_valid, "count and row disagree on full")
  `DEQ_ASSERT(a_refused_push_holds, (accept && is_full && (request.operation == OP_PUSH_FRONT || request.operation == OP_PUSH_BACK)) |=> $stable(count), "refused push changed count")
  `DEQ_ASSERT_ALWAYS(a_count_bound, rst || (count <= CNT_W'(CAPACITY)), "count above capacity")

endmodule

`default_nettype wire

[tb/sv/deque_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches both item channels of the deque. Each accepted request is applied to
// a private ring model, and the resulting deque view is queued. Each accepted
// result is compared field by field with the oldest queued view.
// ----------------------------------------------------------------------------

module deque_result_checker
  import deq_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      request_valid,
  input  wire      request_ready,
  input  request_t request,
  input  wire      result_valid,
  input  wire      result_ready,
  input  result_t  result,
  output int       errors,
  output int       pending
);

  logic signed [DATA_W-1:0] slots [CAPACITY];
  int                       head;
  int                       held;
  result_t                  deque_views [$];
  int                       fail_count = 0;

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("deque mismatch: %s got %h want %h", field, got, want);
    end
  endtask

  function automatic result_t apply_deque_op(request_t item);
    result_t view;
    view.status = ST_DONE;
    case (item.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held >= CAPACITY) begin
          view.status = ST_FULL;
        end else if (item.operation == OP_PUSH_FRONT) begin
          head = (head + CAPACITY - 1) % CAPACITY;
          slots[head] = item.value;
          held++;
        end else begin
          slots[(head + held) % CAPACITY] = item.value;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          view.status = ST_EMPTY;
        end else begin
          if (item.operation == OP_POP_FRONT) begin
            head = (head + 1) % CAPACITY;
          end
          held--;
        end
      end
    endcase
    view.count = COUNT_W'(held);
    if (held != 0) begin
      view.front_value = slots[head];
      view.back_value  = slots[(head + held - 1) % CAPACITY];
    end else begin
      view.front_value = '0;
      view.back_value  = '0;
    end
    return view;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      head = 0;
      held = 0;
      deque_views.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (deque_views.size() == 0) begin
          report("result with no request pending", 32'(result.count), 32'h0);
        end else begin
          want = deque_views[0];
          deque_views.delete(0);
          if (result.status !== want.status)
            report("status", 32'(result.status), 32'(want.status));
          if (result.count !== want.count)
            report("count", 32'(result.count), 32'(want.count));
          if (result.front_value !== want.front_value)
            report("front_value", result.front_value, want.front_value);
          if (result.back_value !== want.back_value)
            report("back_value", result.back_value, want.back_value);
        end
      end
      if (request_valid && request_ready) begin
        deque_views.insert(deque_views.size(), apply_deque_op(request));
      end
    end
    pending <= deque_views.size();
    errors  <= fail_count;
  end

endmodule

[tb/sv/double_ended_queue_ring_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_ring_tb
// Drives push and pop items into the deque with random idle gaps on both
// channels: a directed pass over empty, full and extreme values, then phases
// of random items biased toward filling, draining or balance.
// ----------------------------------------------------------------------------

module double_ended_queue_ring_tb;
  import deq_pkg::*;

  localparam int ITEM_COUNT   = 1800;
  localparam int PHASE_LEN    = 60;
  localparam int LIMIT_CYCLES = 400000;

  logic     clk           = 1'b0;
  logic     rst           = 1'b1;
  logic     request_valid = 1'b0;
  request_t request       = '0;
  logic     result_ready  = 1'b0;
  wire      request_ready;
  wire      result_valid;
  result_t  result;
  int       errors;
  int       pending;
  int       cycles        = 0;
  bit       no_idle       = 1'b0;

  double_ended_queue_ring dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  deque_result_checker watch (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .errors        (errors),
    .pending       (pending)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("double_ended_queue_ring_tb: errors");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_item(op_t op, logic signed [DATA_W-1:0] v);
    int       gap;
    request_t item;
    gap = idle_cycles();
    item.operation = op;
    item.value     = v;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= item;
    do @(posedge clk); while (!request_ready);
  endtask

  task automatic drain();
    request_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    int                       k;
    int                       push_pct;
    bit                       do_push;
    bit                       at_back;
    logic signed [DATA_W-1:0] v;
    push_pct = 50;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty pops, single-entry round trips at the value extremes
    send_item(OP_POP_FRONT, 32'sh7fff_ffff);
    send_item(OP_POP_BACK, 32'sh8000_0000);
    send_item(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(OP_POP_BACK, 32'sh0);
    send_item(OP_PUSH_BACK, 32'sh8000_0000);
    send_item(OP_POP_FRONT, -32'sd1);
    // fill to capacity from both ends, then refused pushes
    for (k = 0; k < CAPACITY; k++) begin
      send_item((k % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                (k % 2) ? 32'sh5555_5555 + k : 32'shaaaa_aaaa - k);
    end
    send_item(OP_PUSH_FRONT, -32'sd1);
    send_item(OP_PUSH_BACK, 32'sh0);
    drain();

    for (k = 0; k < ITEM_COUNT; k++) begin
      if (k % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) drain();
      end
      do_push = ($urandom_range(1, 100) <= push_pct);
      at_back = $urandom_range(0, 1);
      case ($urandom_range(0, 11))
        0:       v = 32'sh7fff_ffff;
        1:       v = 32'sh8000_0000;
        2:       v = 32'sh0;
        3:       v = -32'sd1;
        default: v = $urandom;
      endcase
      if (do_push) begin
        send_item(at_back ? OP_PUSH_BACK : OP_PUSH_FRONT, v);
      end else begin
        send_item(at_back ? OP_POP_BACK : OP_POP_FRONT, v);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("double_ended_queue_ring_tb: clean");
    end else begin
      $display("double_ended_queue_ring_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/deq_pkg.sv
design/deq_cell.sv
design/deq_row.sv
design/double_ended_queue_ring.sv
tb/sv/deque_result_checker.sv
tb/sv/double_ended_queue_ring_tb.sv
